@@ design/sdt_pkg.sv @@
`default_nettype none
package sdt_pkg;
    localparam int SLOTS = 256;
    localparam int SW = $clog2(SLOTS);

    localparam logic [2:0] OP_OPEN    = 3'd0;
    localparam logic [2:0] OP_BIND    = 3'd1;
    localparam logic [2:0] OP_LISTEN  = 3'd2;
    localparam logic [2:0] OP_CONNECT = 3'd3;
    localparam logic [2:0] OP_CLOSE   = 3'd4;
    localparam logic [2:0] OP_LOOKUP  = 3'd5;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_FAMILY  = 3'd2;
    localparam logic [2:0] ST_NOTSOCK = 3'd3;
    localparam logic [2:0] ST_NOTTCP  = 3'd4;

    localparam logic [2:0] MODE_IDLE      = 3'd0;
    localparam logic [2:0] MODE_REQUESTED = 3'd1;
    localparam logic [2:0] MODE_BOUND     = 3'd2;
    localparam logic [2:0] MODE_LISTENING = 3'd3;
    localparam logic [2:0] MODE_OUTBOUND  = 3'd4;

    localparam logic [1:0] KIND_DGRAM  = 2'd0;
    localparam logic [1:0] KIND_STREAM = 2'd1;
    localparam logic [7:0] PROTO_TCP   = 8'd6;

    // one socket entry
    typedef struct packed {
        logic        valid;
        logic [1:0]  kind;
        logic        is_tcp;
        logic [2:0]  mode;
        logic [31:0] laddr;
        logic [15:0] lport;
        logic [31:0] raddr;
        logic [15:0] rport;
    } t_entry;

    // command word held at the ring head while the entries rotate past it
    typedef struct packed {
        logic [2:0]  op;
        logic [SW-1:0] slot;
        logic        fam;
        logic [1:0]  kind;
        logic [7:0]  proto;
        logic [31:0] aip;
        logic [15:0] aport;
        logic [31:0] pip;
        logic [15:0] pport;
    } t_cmd;
endpackage
`default_nettype wire

@@ design/sdt_cell.sv @@
`default_nettype none
// One slot. Entries rotate around the ring; the cell at the ring head is
// examined and modified by the controller on its way through.
module sdt_cell (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_shift,
    input  wire sdt_pkg::t_entry i_prev,
    output sdt_pkg::t_entry     o_entry
);
    sdt_pkg::t_entry r_entry;

    // shift register stage; valid, mode and addresses clear at reset,
    // kind and tcp flag are only meaningful once the slot is opened
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
            r_entry.mode  <= sdt_pkg::MODE_IDLE;
            r_entry.laddr <= '0;
            r_entry.lport <= '0;
            r_entry.raddr <= '0;
            r_entry.rport <= '0;
        end else if (i_shift) begin
            r_entry <= i_prev;
        end
    end
    assign o_entry = r_entry;
endmodule
`default_nettype wire

@@ design/sdt_head.sv @@
`default_nettype none
// Ring head: evaluates the entry passing through and writes back the
// entry with any change applied. Purely combinational per step.
module sdt_head (
    input  wire sdt_pkg::t_cmd   i_cmd,
    input  wire logic [sdt_pkg::SW-1:0] i_idx,
    input  wire logic            i_done,
    input  wire sdt_pkg::t_entry i_entry,
    output sdt_pkg::t_entry      o_entry,
    output logic                 o_hit,
    output logic [2:0]           o_status
);
    logic       tcp;
    logic [2:0] lmode;
    logic [2:0] str;
    logic       addressed;

    always_comb begin
        o_entry  = i_entry;
        o_hit    = 1'b0;
        o_status = sdt_pkg::ST_OK;
        tcp      = (i_cmd.kind == sdt_pkg::KIND_STREAM);
        lmode    = tcp ? sdt_pkg::MODE_LISTENING : sdt_pkg::MODE_BOUND;
        str      = 3'(i_entry.laddr == i_cmd.aip) + 3'(i_entry.lport == i_cmd.aport)
                 + 3'(i_entry.mode == lmode && i_entry.laddr == '0);
        if (i_entry.mode == sdt_pkg::MODE_OUTBOUND)
            str = str + 3'(i_entry.raddr == i_cmd.pip) + 3'(i_entry.rport == i_cmd.pport);
        addressed = (i_idx == i_cmd.slot) && i_entry.valid;
        if (!i_done) begin
            unique case (i_cmd.op)
                sdt_pkg::OP_OPEN: begin
                    if (!i_entry.valid) begin
                        o_hit = 1'b1;
                        if (i_cmd.fam == 1'b0) begin
                            o_entry.valid  = 1'b1;
                            o_entry.kind   = i_cmd.kind;
                            o_entry.is_tcp = (i_cmd.kind == sdt_pkg::KIND_STREAM) ||
                                (i_cmd.kind[1] && i_cmd.proto == sdt_pkg::PROTO_TCP);
                            o_entry.mode   = sdt_pkg::MODE_REQUESTED;
                            o_entry.laddr  = '0;
                            o_entry.lport  = '0;
                            o_entry.raddr  = '0;
                            o_entry.rport  = '0;
                        end else begin
                            o_status = sdt_pkg::ST_FAMILY;
                        end
                    end
                end
                sdt_pkg::OP_BIND: if (addressed) begin
                    o_hit = 1'b1;
                    if (i_cmd.fam) o_status = sdt_pkg::ST_FAMILY;
                    else begin
                        o_entry.laddr = i_cmd.aip;
                        o_entry.lport = i_cmd.aport;
                        o_entry.mode  = sdt_pkg::MODE_BOUND;
                    end
                end
                sdt_pkg::OP_LISTEN: if (addressed) begin
                    o_hit = 1'b1;
                    o_entry.mode = sdt_pkg::MODE_LISTENING;
                end
                sdt_pkg::OP_CONNECT: if (addressed) begin
                    o_hit = 1'b1;
                    if (i_cmd.fam) o_status = sdt_pkg::ST_FAMILY;
                    else if (!i_entry.is_tcp) o_status = sdt_pkg::ST_NOTTCP;
                    else begin
                        o_entry.raddr = i_cmd.aip;
                        o_entry.rport = i_cmd.aport;
                        o_entry.mode  = sdt_pkg::MODE_OUTBOUND;
                    end
                end
                sdt_pkg::OP_CLOSE: if (addressed) begin
                    o_hit = 1'b1;
                    o_entry.valid = 1'b0;
                    o_entry.mode  = sdt_pkg::MODE_IDLE;
                end
                sdt_pkg::OP_LOOKUP: begin
                    if (!i_cmd.kind[1] && i_entry.valid && i_entry.kind == i_cmd.kind
                        && i_entry.is_tcp == tcp
                        && ((i_entry.mode == lmode && str == 3'd2)
                            || (i_entry.mode == sdt_pkg::MODE_OUTBOUND && str == 3'd4)))
                        o_hit = 1'b1;
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ design/socket_demux_table_core.sv @@
`default_nettype none
// Socket demultiplexing table, SLOTS entries held in a ring of cells.
// Input channel: i_valid/o_ready with one command word (operation, slot,
// family, kind, protocol number, address/port, peer address/port).
// Output channel: o_valid/i_ready with status, found and slot_out.
// Every command takes one full rotation of the ring, with the ring head
// examining one entry per cycle. The result is presented in the result
// state after the rotation; a new word is taken only once the result has
// been taken (accept state, scan of all SLOTS entries, result state).
// The first matching entry (free slot for open, addressed slot, or lookup
// match) is recorded and later entries pass unchanged. The ring ends back
// in its original order.
// The result sits in an output register; o_ready stays low until it has
// been taken, so a stalled receiver holds off new commands.
// Reset (synchronous, active low) empties every slot at once.
module socket_demux_table_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [2:0]  i_operation,
    input  wire logic [7:0]  i_slot,
    input  wire logic        i_address_family,
    input  wire logic [1:0]  i_kind,
    input  wire logic [7:0]  i_protocol_number,
    input  wire logic [31:0] i_addr_ip,
    input  wire logic [15:0] i_addr_port,
    input  wire logic [31:0] i_peer_ip,
    input  wire logic [15:0] i_peer_port,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [2:0]       o_status,
    output logic             o_found,
    output logic [7:0]       o_slot_out
);
    localparam int SW = sdt_pkg::SW;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    t_state          r_state, n_state;
    sdt_pkg::t_cmd   r_cmd;
    logic [SW:0]     r_cnt;
    logic            r_done;
    logic [2:0]      r_st;
    logic            r_fnd;
    logic [SW-1:0]   r_sl;
    logic            shift;
    logic            hit;
    logic [2:0]      hstat;
    sdt_pkg::t_entry ring [sdt_pkg::SLOTS];
    sdt_pkg::t_entry head_out;
    logic            out_of_range;

    assign shift = (r_state == S_SCAN);
    // slot beyond table depth is never a socket
    assign out_of_range = (SW < 8) && ((32'(i_slot) >> SW) != 0);

    sdt_head u_head (
        .i_cmd(r_cmd), .i_idx(r_cnt[SW-1:0]), .i_done(r_done),
        .i_entry(ring[0]), .o_entry(head_out), .o_hit(hit), .o_status(hstat)
    );

    // ring: cell k takes from k+1, the last takes the head's write-back
    for (genvar k = 0; k < sdt_pkg::SLOTS; k++) begin : g_cell
        sdt_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_shift(shift),
            .i_prev((k == sdt_pkg::SLOTS - 1) ? head_out : ring[(k + 1) % sdt_pkg::SLOTS]),
            .o_entry(ring[k])
        );
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid) n_state = S_SCAN;
            S_SCAN: if (r_cnt == (SW+1)'(sdt_pkg::SLOTS - 1)) n_state = S_OUT;
            S_OUT:  if (i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // command capture, scan bookkeeping and result
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_cmd <= '{op: i_operation, slot: i_slot[SW-1:0], fam: i_address_family,
                       kind: i_kind, proto: i_protocol_number, aip: i_addr_ip,
                       aport: i_addr_port, pip: i_peer_ip, pport: i_peer_port};
            r_cnt  <= '0;
            r_done <= out_of_range;
            r_fnd  <= 1'b0;
            r_sl   <= '0;
            if (i_operation == sdt_pkg::OP_OPEN)
                r_st <= sdt_pkg::ST_FULL;
            else if (i_operation == sdt_pkg::OP_BIND || i_operation == sdt_pkg::OP_LISTEN
                     || i_operation == sdt_pkg::OP_CONNECT
                     || i_operation == sdt_pkg::OP_CLOSE)
                r_st <= sdt_pkg::ST_NOTSOCK;
            else
                r_st <= sdt_pkg::ST_OK;
        end else if (shift) begin
            r_cnt <= r_cnt + 1'b1;
            if (hit && !r_done) begin
                r_done <= 1'b1;
                r_st   <= hstat;
                if ((r_cmd.op == sdt_pkg::OP_OPEN && hstat == sdt_pkg::ST_OK)
                    || r_cmd.op == sdt_pkg::OP_LOOKUP) begin
                    r_fnd <= 1'b1;
                    r_sl  <= r_cnt[SW-1:0];
                end
            end
        end
    end

    assign o_ready    = (r_state == S_IDLE);
    assign o_valid    = (r_state == S_OUT);
    assign o_status   = r_st;
    assign o_found    = r_fnd;
    assign o_slot_out = 8'(r_sl);

    // a found result always has status ok
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_found |-> o_status == sdt_pkg::ST_OK)
        else $error("found with bad status");
    // a result is only presented straight after a scan
    a_scan_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state) == S_SCAN)
        else $error("result without scan");
    // never ready while a result waits
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready))
        else $error("ready while result pending");
endmodule
`default_nettype wire
